FILE: hw/rtl/psfc_pkg.sv
`timescale 1ns / 1ps
package psfc_pkg;
  localparam int SampleW = 32;
  typedef enum logic [1:0] {
    FMT_FLOAT = 2'd0,
    FMT_INT32 = 2'd1,
    FMT_INT16 = 2'd2,
    FMT_UINT8 = 2'd3
  } fmt_t;
  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_FORMAT    = 2'd1,
    REG_NORMALIZE = 2'd2
  } reg_idx_t;
  // Operation chosen for one word
  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_I2F   = 3'd1,
    OP_DEC16 = 3'd2,
    OP_DEC8  = 3'd3,
    OP_F2I   = 3'd4,
    OP_ENC16 = 3'd5,
    OP_ENC8  = 3'd6
  } op_t;
  typedef struct packed {
    logic valid;
    logic stall;
  } stage_ctl_t;
endpackage

FILE: hw/rtl/pcm_sample_format_converter_top.sv
`timescale 1ns / 1ps
// Converts one 32-bit sample word per cycle between signed 32-bit PCM and
// float32 / int32 / int16 / uint8 (direction and format set through cfg_).
// Three register stages (unpack, normalize/align, round/pack): the first
// stage loads at the accepting edge and the word reaches out_ from the
// third, and a new word may enter every cycle unless stalled. The pipeline
// stalls as a whole while out_valid is held without out_ready, and in_ready
// drops for those cycles. clipped flags float-to-PCM clamping or NaN.
module pcm_sample_format_converter_top import psfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits,
  output logic        out_clipped
);
  logic dir_r, norm_r;
  fmt_t fmt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      fmt_r  <= FMT_FLOAT;
      norm_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION: dir_r  <= cfg_wdata[0];
        REG_FORMAT:    fmt_r  <= fmt_t'(cfg_wdata);
        REG_NORMALIZE: norm_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end
  // pick operation from config
  op_t op;
  always_comb begin
    if (!dir_r) begin
      if (norm_r || fmt_r == FMT_FLOAT) op = OP_I2F;
      else begin
        case (fmt_r)
          FMT_INT16: op = OP_DEC16;
          FMT_UINT8: op = OP_DEC8;
          default:   op = OP_PASS;
        endcase
      end
    end else begin
      case (fmt_r)
        FMT_FLOAT: op = OP_F2I;
        FMT_INT16: op = OP_ENC16;
        FMT_UINT8: op = OP_ENC8;
        default:   op = OP_PASS;
      endcase
    end
  end
  // whole pipe holds when the output word is not taken
  logic stall;
  assign stall    = out_valid && !out_ready;
  assign in_ready = !stall;
  logic v1, v2;
  op_t op1, op2;
  logic [31:0] val1, val2;
  logic s1, s2;
  logic [7:0] e1;
  logic [4:0] p2;
  logic [1:0] sp2;
  psfc_stage1 u_s1 (
    .clk, .rst_n, .ctl('{valid: in_valid, stall: stall}), .op, .x(in_sample_bits),
    .v_r(v1), .op_r(op1), .val_r(val1), .sign_r(s1), .exp_r(e1)
  );
  psfc_stage2 u_s2 (
    .clk, .rst_n, .ctl('{valid: v1, stall: stall}), .op(op1), .val(val1),
    .sign(s1), .exp(e1), .v_r(v2), .op_r(op2), .val_r(val2), .sign_r(s2),
    .pos_r(p2), .spec_r(sp2)
  );
  psfc_stage3 u_s3 (
    .clk, .rst_n, .ctl('{valid: v2, stall: stall}), .op(op2), .val(val2),
    .sign(s2), .pos(p2), .spec(sp2), .v_r(out_valid), .res_r(out_result_bits),
    .clip_r(out_clipped)
  );
`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("in_ready mismatch");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("word lost in pipe");
`endif
endmodule

FILE: hw/rtl/psfc_stage1.sv
`timescale 1ns / 1ps
// Stage 1: classify, magnitude / simple results, float field unpack.
module psfc_stage1 import psfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl,
  input  op_t         op,
  input  logic [31:0] x,
  output logic        v_r,
  output op_t         op_r,
  output logic [31:0] val_r,
  output logic        sign_r,
  output logic [7:0]  exp_r
);
  logic [31:0] val_nxt;
  always_comb begin
    case (op)
      OP_I2F:   val_nxt = x[31] ? (32'd0 - x) : x;
      OP_DEC16: val_nxt = {16'd0, x[31:16]};
      OP_DEC8:  val_nxt = {24'd0, x[31:24] ^ 8'h80};
      OP_F2I:   val_nxt = {8'd0, 1'b1, x[22:0]};
      OP_ENC16: val_nxt = {x[15:0], 16'd0};
      OP_ENC8:  val_nxt = {x[7:0] ^ 8'h80, 24'd0};
      default:  val_nxt = x;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!ctl.stall) begin
      v_r <= ctl.valid;
    end
    if (!ctl.stall) begin
      op_r   <= op;
      val_r  <= val_nxt;
      sign_r <= x[31];
      exp_r  <= x[30:23];
    end
  end
endmodule

FILE: hw/rtl/psfc_stage2.sv
`timescale 1ns / 1ps
// Stage 2: leading one count and normalizing shift for int to float;
// range check and alignment shift for float to int.
module psfc_stage2 import psfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl,
  input  op_t         op,
  input  logic [31:0] val,
  input  logic        sign,
  input  logic [7:0]  exp,
  output logic        v_r,
  output op_t         op_r,
  output logic [31:0] val_r,
  output logic        sign_r,
  output logic [4:0]  pos_r,
  output logic [1:0]  spec_r
);
  logic [4:0]  p;
  logic [31:0] norm, ali;
  logic [1:0]  spec;
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (val[i]) p = 5'(i);
    end
    norm = val << (5'd31 - p);
    // float to int: value = 1.m * 2^(exp-127) * 2^31 = 1.m * 2^(exp-96)
    spec = 2'd0;
    ali  = 32'd0;
    if (exp == 8'hFF && val[22:0] != 23'd0) begin
      spec = 2'd3;
    end else if (exp >= 8'd127) begin
      // |value| >= 2^31; exactly -2^31 still fits
      spec = (sign && exp == 8'd127 && val[22:0] == 23'd0) ? 2'd2 : 2'd1;
    end else if (exp >= 8'd96) begin
      // leading one lands on bit exp-96
      ali = {val[23:0], 8'd0} >> (8'd127 - exp);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!ctl.stall) begin
      v_r <= ctl.valid;
    end
    if (!ctl.stall) begin
      op_r   <= op;
      sign_r <= sign;
      pos_r  <= p;
      spec_r <= spec;
      case (op)
        OP_I2F:  val_r <= norm;
        OP_F2I:  val_r <= ali;
        default: val_r <= val;
      endcase
    end
  end
endmodule

FILE: hw/rtl/psfc_stage3.sv
`timescale 1ns / 1ps
// Stage 3: rounding and packing into the result word.
module psfc_stage3 import psfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl,
  input  op_t         op,
  input  logic [31:0] val,
  input  logic        sign,
  input  logic [4:0]  pos,
  input  logic [1:0]  spec,
  output logic        v_r,
  output logic [31:0] res_r,
  output logic        clip_r
);
  logic [31:0] res;
  logic        clip;
  logic [24:0] mant;
  logic        rnd;
  always_comb begin
    clip = 1'b0;
    rnd  = val[7] && (val[6:0] != 7'd0 || val[8]);
    mant = {1'b0, val[31:8]} + {24'd0, rnd};
    case (op)
      OP_I2F: begin
        if (val == 32'd0) res = 32'd0;
        else res = {sign, 31'd0} |
                   ((32'({3'd0, pos} + 8'd96) << 23) + (32'(mant) - 32'h800000));
      end
      OP_F2I: begin
        case (spec)
          2'd3: begin res = 32'd0; clip = 1'b1; end
          2'd1: begin res = sign ? 32'h80000000 : 32'h7FFFFFFF; clip = 1'b1; end
          2'd2: res = 32'h80000000;
          default: res = sign ? (32'd0 - val) : val;
        endcase
      end
      default: res = val;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!ctl.stall) begin
      v_r <= ctl.valid;
    end
    if (!ctl.stall) begin
      res_r  <= res;
      clip_r <= clip;
    end
  end
endmodule

FILE: verif/pcm_sample_format_converter_top_test.sv
`timescale 1ns / 1ps
// Pipeline is three stages deep, one word per cycle, whole-pipe stall on
// output backpressure.
module pcm_sample_format_converter_top_test;
  import psfc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_sample_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result_bits;
  logic        out_clipped;

  pcm_sample_format_converter_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_bits (in_sample_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_bits(out_result_bits),
    .out_clipped    (out_clipped)
  );

  typedef struct packed {
    logic [31:0] bits;
    logic        clip;
  } conv_t;

  // Predictor copy of the register file.
  logic  dir_q;
  fmt_t  fmt_q;
  logic  norm_q;

  logic [31:0] pending_words[$];
  conv_t       expected_conv[$];
  int          errors;
  bit          idle_ok;      // random gaps allowed while set
  bit          hold_out;     // long receiver hold-off request
  int          in_gap;
  int          out_gap;
  int          hold_cnt;

  // int32 -> float32 (RNE), scaled by 2^-31: exponent bias shifts by 31.
  function automatic logic [31:0] pcm_to_float(logic [31:0] x);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    int          p;
    int          s;
    sgn = x[31];
    mag = sgn ? -x : x;
    if (mag == 0) return 32'h0;
    p = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = i;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      s = p - 23;
      rem = mag & ((32'h1 << s) - 1);
      half = 32'h1 << (s - 1);
      mant = mag >> s;
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
    end
    return {sgn, 31'h0} | (((p + 96) << 23) + (mant - 32'h800000));
  endfunction

  // float32 bits -> int32 after *2^31, clamp and truncation.
  function automatic conv_t float_to_pcm(logic [31:0] f);
    conv_t       r;
    logic [7:0]  e;
    logic [23:0] m;
    logic [63:0] mag;
    int          sh;
    e = f[30:23];
    m = {1'b1, f[22:0]};
    r.clip = 1'b0;
    if (e == 8'hFF && f[22:0] != 0) begin
      r.bits = 32'h0;
      r.clip = 1'b1;
      return r;
    end
    if (e == 0) begin
      r.bits = 32'h0;  // denormals and zero truncate to 0
      return r;
    end
    // value*2^31 = m * 2^(e - 127 - 23 + 31)
    sh = int'(e) - 119;
    if (sh >= 8) begin
      // |v| >= 2^31
      if (!f[31]) begin
        r.bits = 32'h7FFFFFFF;
        r.clip = 1'b1;
      end else begin
        r.bits = 32'h80000000;
        r.clip = (sh > 8) || (f[22:0] != 0);
      end
      return r;
    end
    if (sh >= 0) mag = {40'h0, m} << sh;
    else if (sh > -32) mag = {40'h0, m} >> (-sh);
    else mag = 64'h0;
    r.bits = f[31] ? -mag[31:0] : mag[31:0];
    return r;
  endfunction

  function automatic conv_t convert_sample(logic [31:0] x);
    conv_t r;
    r.clip = 1'b0;
    if (!dir_q) begin
      if (norm_q || fmt_q == FMT_FLOAT) r.bits = pcm_to_float(x);
      else if (fmt_q == FMT_INT32) r.bits = x;
      else if (fmt_q == FMT_INT16) r.bits = {16'h0, x[31:16]};
      else r.bits = {24'h0, x[31:24] ^ 8'h80};
    end else begin
      if (fmt_q == FMT_FLOAT) r = float_to_pcm(x);
      else if (fmt_q == FMT_INT32) r.bits = x;
      else if (fmt_q == FMT_INT16) r.bits = {x[15:0], 16'h0};
      else r.bits = {x[7:0] ^ 8'h80, 24'h0};
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Driver: the prediction is taken when the word is handed to the DUT,
  // so config changes only happen with the queue drained.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_sample_bits <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_conv.push_back(convert_sample(in_sample_bits));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_sample_bits <= pending_words.pop_front();
          if (idle_ok && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver-side stall.
  always @(posedge clk) begin
    conv_t exp_c;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_conv.size() == 0) begin
          $display("%t unexpected word %h/%b", $realtime, out_result_bits, out_clipped);
          errors++;
        end else begin
          exp_c = expected_conv.pop_front();
          if (out_result_bits !== exp_c.bits) begin
            $display("%t result_bits exp %h got %h", $realtime, exp_c.bits, out_result_bits);
            errors++;
          end
          if (out_clipped !== exp_c.clip) begin
            $display("%t clipped exp %b got %b", $realtime, exp_c.clip, out_clipped);
            errors++;
          end
        end
      end
      if (hold_out && hold_cnt < 60) begin
        hold_cnt <= hold_cnt + 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_ok && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 13);
      end
      if (!hold_out) hold_cnt <= 0;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DIRECTION: dir_q = val[0];
      REG_FORMAT:    fmt_q = fmt_t'(val);
      default:       norm_q = val[0];
    endcase
  endtask

  task automatic set_mode(logic d, fmt_t f, logic n);
    write_reg(REG_DIRECTION, {1'b0, d});
    write_reg(REG_FORMAT, f);
    write_reg(REG_NORMALIZE, {1'b0, n});
  endtask

  // Wait until every issued word has come back, plus pipeline slack.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_conv.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Random sample biased toward the interesting float encodings.
  function automatic logic [31:0] rand_word(logic d, fmt_t f);
    logic [31:0] w;
    w = $urandom;
    if (d && f == FMT_FLOAT) begin
      case ($urandom_range(0, 5))
        0: w[30:23] = 8'd127 + 8'($urandom_range(0, 2)) - 8'd1; // near 1.0
        1: w[30:23] = 8'd255;                                     // inf / NaN
        2: w[30:23] = 8'($urandom_range(90, 126));               // in range
        3: w[30:23] = 8'($urandom_range(0, 3));                  // tiny
        default: ;
      endcase
    end
    return w;
  endfunction

  logic [31:0] edge_words[18] = '{
    32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
    32'h01000001, 32'h00FFFFFF, 32'h3F800000, 32'hBF800000, 32'h7F800000,
    32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF, 32'h3F7FFFFF, 32'hBF800001,
    32'h0000807F, 32'h40000000, 32'h00800000
  };

  initial begin
    logic d;
    fmt_t f;
    errors = 0;
    idle_ok = 1'b0;
    hold_out = 1'b0;
    dir_q = 1'b0;
    fmt_q = FMT_FLOAT;
    norm_q = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every edge word under every mode, normalize both ways.
    for (int m = 0; m < 16; m++) begin
      set_mode(m[3], fmt_t'(m[1:0]), m[2]);
      foreach (edge_words[i]) pending_words.push_back(edge_words[i]);
      drain();
    end

    // Random phases, all but the last with idling; one phase also stalls the receiver long.
    idle_ok = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      d = 1'($urandom_range(0, 1));
      f = fmt_t'($urandom_range(0, 3));
      set_mode(d, f, 1'($urandom_range(0, 1)));
      if (ph == 7) idle_ok = 1'b0;
      if (ph == 3) hold_out = 1'b1;
      for (int i = 0; i < 50; i++) pending_words.push_back(rand_word(d, f));
      if (ph == 3) begin
        repeat (80) @(posedge clk);
        hold_out = 1'b0;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
